// ===== hw/rtl/asmlex_pkg.sv =====
// ----------------------------------------------------------------------------
// asmlex_pkg
// Shared types, codes and character classes for the assembly source lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package asmlex_pkg;

	// Register name length checked when a word closes
	localparam int unsigned REG_NAME_LEN = 2;

	// Token queue geometry
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// Configuration register byte address (register 0)
	localparam int unsigned CFG_AW = 4;
	localparam logic [CFG_AW-1:0] ADDR_SUFFIX_MASK = 4'h0;

	// Character codes
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_UR    = 8'h52;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	// Token type codes
	typedef enum logic [3:0] {
		TOK_NUMBER    = 4'd0,
		TOK_DIRECTIVE = 4'd1,
		TOK_REGISTER  = 4'd2,
		TOK_IDENT     = 4'd3,
		TOK_COLON     = 4'd4,
		TOK_COMMA     = 4'd5,
		TOK_HASH      = 4'd6,
		TOK_LPAREN    = 4'd7,
		TOK_MINUS     = 4'd8,
		TOK_PLUS      = 4'd9,
		TOK_RPAREN    = 4'd10,
		TOK_UNKNOWN   = 4'd11,
		TOK_END       = 4'd12
	} tok_type_t;

	// Scanner modes
	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_DEC     = 3'd2,
		MODE_ZERO    = 3'd3,
		MODE_HEX     = 3'd4,
		MODE_BIN     = 3'd5,
		MODE_WORD    = 3'd6,
		MODE_DIR     = 3'd7
	} mode_t;

	// One reported token
	typedef struct packed {
		tok_type_t   ttype;
		logic [15:0] line;
		logic [7:0]  col;
		logic [8:0]  len;
		logic        last;
	} token_t;

	// Tokens produced by the scanner for one accepted byte
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	// Queue status toward the top level
	typedef struct packed {
		logic [QAW:0] fill;
		logic         nonempty;
		logic         no_room;
	} qstat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7A);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_upper(c) || is_lower(c) || is_digit(c) || (c == CH_DOT) || (c == CH_UNDER);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	// Bit of the suffix mask that governs a register's second byte
	function automatic logic mask_allows(input logic [7:0] c, input logic [63:0] mask);
		logic [7:0] idx;
		logic       ok;
		idx = 8'd0;
		ok  = 1'b1;
		if (is_digit(c)) begin
			idx = c - 8'h30;
		end else if (is_upper(c)) begin
			idx = c - 8'h41 + 8'd10;
		end else if (is_lower(c)) begin
			idx = c - 8'h61 + 8'd36;
		end else if (c == CH_DOT) begin
			idx = 8'd62;
		end else if (c == CH_UNDER) begin
			idx = 8'd63;
		end else begin
			ok = 1'b0;
		end
		return ok && mask[idx[5:0]];
	endfunction

	function automatic tok_type_t punct_type(input logic [7:0] c);
		tok_type_t t;
		case (c)
			CH_COLON: t = TOK_COLON;
			CH_COMMA: t = TOK_COMMA;
			CH_HASH:  t = TOK_HASH;
			CH_LPAR:  t = TOK_LPAREN;
			CH_MINUS: t = TOK_MINUS;
			CH_PLUS:  t = TOK_PLUS;
			CH_RPAR:  t = TOK_RPAREN;
			default:  t = TOK_UNKNOWN;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asmlex_front.sv =====
// ----------------------------------------------------------------------------
// asmlex_front
// Scanner: classifies each accepted byte, tracks the open token and position,
// and hands zero, one or two finished tokens per byte to the token queue.
// ----------------------------------------------------------------------------
`default_nettype none

module asmlex_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         character,
	input  wire logic               src_end,
	input  wire logic [63:0]        suffix_mask,
	output asmlex_pkg::push_t       push
);
	import asmlex_pkg::*;

	mode_t       mode_q, mode_d;
	logic [7:0]  tok_col_q, tok_col_d;
	logic [8:0]  tok_len_q, tok_len_d;
	logic        starts_r_q, starts_r_d;
	logic        suffix_ok_q, suffix_ok_d;
	logic [15:0] line_q, line_d;
	logic [8:0]  colcnt_q, colcnt_d;
	logic        line_used_q, line_used_d;

	logic        open_tok;
	logic        taken;
	logic        is_nl;
	logic        emit_close;
	logic        emit_punct;
	logic        start_tok;
	logic [7:0]  col_sat;
	logic [15:0] line_inc;
	token_t      close_tok;
	token_t      punct_tok;
	token_t      end_tok;

	// Hold scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			tok_col_q   <= '0;
			tok_len_q   <= '0;
			starts_r_q  <= 1'b0;
			suffix_ok_q <= 1'b0;
			line_q      <= '0;
			colcnt_q    <= '0;
			line_used_q <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_d;
			tok_col_q   <= tok_col_d;
			tok_len_q   <= tok_len_d;
			starts_r_q  <= starts_r_d;
			suffix_ok_q <= suffix_ok_d;
			line_q      <= line_d;
			colcnt_q    <= colcnt_d;
			line_used_q <= line_used_d;
		end
	end

	// Build candidate tokens
	always_comb begin
		open_tok = (mode_q != MODE_IDLE) && (mode_q != MODE_COMMENT);
		col_sat  = colcnt_q[8] ? 8'hFF : colcnt_q[7:0];
		line_inc = (line_q != 16'hFFFF) ? line_q + 16'd1 : line_q;

		close_tok.line = line_q;
		close_tok.col  = tok_col_q;
		close_tok.len  = tok_len_q;
		close_tok.last = 1'b0;
		case (mode_q)
			MODE_DIR:  close_tok.ttype = TOK_DIRECTIVE;
			MODE_WORD: close_tok.ttype = (starts_r_q && suffix_ok_q &&
				(tok_len_q == 9'(REG_NAME_LEN))) ? TOK_REGISTER : TOK_IDENT;
			default:   close_tok.ttype = TOK_NUMBER;
		endcase

		punct_tok.ttype = punct_type(character);
		punct_tok.line  = line_q;
		punct_tok.col   = col_sat;
		punct_tok.len   = 9'd1;
		punct_tok.last  = 1'b1;

		end_tok.ttype = TOK_END;
		end_tok.line  = line_used_q ? line_inc : line_q;
		end_tok.col   = '0;
		end_tok.len   = '0;
		end_tok.last  = 1'b1;
	end

	// Classify the byte and advance state
	always_comb begin
		is_nl       = (character == CH_NL);
		mode_d      = mode_q;
		tok_col_d   = tok_col_q;
		tok_len_d   = tok_len_q;
		starts_r_d  = starts_r_q;
		suffix_ok_d = suffix_ok_q;
		taken       = 1'b0;
		start_tok   = 1'b0;

		case (mode_q)
			MODE_DEC: taken = is_digit(character);
			MODE_ZERO: begin
				if ((character == CH_LX) || (character == CH_UX)) begin
					mode_d = MODE_HEX;
					taken  = 1'b1;
				end else if ((character == CH_LB) || (character == CH_UB)) begin
					mode_d = MODE_BIN;
					taken  = 1'b1;
				end
			end
			MODE_HEX: taken = is_hex(character);
			MODE_BIN: taken = (character == CH_ZERO) || (character == CH_ONE);
			MODE_WORD, MODE_DIR: begin
				taken = is_word(character);
				if (taken && (tok_len_q == 9'd1)) begin
					suffix_ok_d = mask_allows(character, suffix_mask);
				end
			end
			MODE_COMMENT: taken = !is_nl;
			default: taken = 1'b0;
		endcase

		emit_close = !taken && open_tok;
		emit_punct = !taken && !is_space(character) && (character != CH_SEMI) &&
			!is_word(character);

		if (taken) begin
			if ((mode_q != MODE_COMMENT) && (tok_len_q != 9'd256)) begin
				tok_len_d = tok_len_q + 9'd1;
			end
		end else begin
			mode_d = MODE_IDLE;
			if (character == CH_SEMI) begin
				mode_d = MODE_COMMENT;
			end else if (is_word(character)) begin
				start_tok = 1'b1;
				if (is_digit(character)) begin
					mode_d = (character == CH_ZERO) ? MODE_ZERO : MODE_DEC;
				end else begin
					mode_d = (character == CH_DOT) ? MODE_DIR : MODE_WORD;
				end
			end
		end

		if (start_tok) begin
			tok_col_d   = col_sat;
			tok_len_d   = 9'd1;
			starts_r_d  = (character == CH_LR) || (character == CH_UR);
			suffix_ok_d = 1'b0;
		end

		if (is_nl) begin
			line_d      = line_inc;
			colcnt_d    = '0;
			line_used_d = 1'b0;
		end else begin
			line_d      = line_q;
			colcnt_d    = (colcnt_q != 9'd256) ? colcnt_q + 9'd1 : colcnt_q;
			line_used_d = 1'b1;
		end

		// End of source: close, report end, return to reset
		if (src_end) begin
			mode_d      = MODE_IDLE;
			tok_col_d   = '0;
			tok_len_d   = '0;
			starts_r_d  = 1'b0;
			suffix_ok_d = 1'b0;
			line_d      = '0;
			colcnt_d    = '0;
			line_used_d = 1'b0;
		end
	end

	// Pack the tokens for the queue, first one in slot zero
	always_comb begin
		push.tok1 = src_end ? end_tok : punct_tok;
		if (src_end) begin
			push.count = open_tok ? 2'd2 : 2'd1;
			push.tok0  = open_tok ? close_tok : end_tok;
		end else begin
			push.count = {1'b0, emit_close} + {1'b0, emit_punct};
			push.tok0  = emit_close ? close_tok : punct_tok;
			push.tok0.last = !(emit_close && emit_punct);
		end
		if (!accept) begin
			push.count = 2'd0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/asmlex_queue.sv =====
// ----------------------------------------------------------------------------
// asmlex_queue
// Short token queue between scanner and output stage: takes up to two tokens
// per cycle, gives up one.
// ----------------------------------------------------------------------------
`default_nettype none

module asmlex_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  asmlex_pkg::push_t       push,
	input  wire logic               pop,
	output asmlex_pkg::token_t      head,
	output asmlex_pkg::qstat_t      stat
);
	import asmlex_pkg::*;

	token_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   fill_q;
	logic [QAW-1:0] wr_ptr_1;

	assign wr_ptr_1 = wr_ptr_q + QAW'(1);

	// Store incoming tokens
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_1] <= push.tok1;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			fill_q <= fill_q + (QAW+1)'(push.count) - (QAW+1)'(pop);
		end
	end

	assign head          = mem_q[rd_ptr_q];
	assign stat.fill     = fill_q;
	assign stat.nonempty = (fill_q != '0);
	assign stat.no_room  = (fill_q > (QAW+1)'(QDEPTH - 2));

endmodule

`default_nettype wire

// ===== hw/rtl/asmlex_back.sv =====
// ----------------------------------------------------------------------------
// asmlex_back
// Output stage: registers one token from the queue and presents it until the
// receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module asmlex_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  asmlex_pkg::token_t      head,
	input  wire logic               head_valid,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output asmlex_pkg::token_t      out_tok
);
	import asmlex_pkg::*;

	logic   valid_q;
	token_t tok_q;

	// Refill when empty or when the current transfer completes
	assign pop = head_valid && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q <= head;
		end
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

endmodule

`default_nettype wire

// ===== hw/rtl/assembly_source_lexer_top.sv =====
// ----------------------------------------------------------------------------
// assembly_source_lexer_top
// Assembly source lexer: bytes in, typed tokens with line, column and length out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one source byte per transfer,
//   or an end-of-file mark. Output channel (out_valid/out_stall) carries one
//   token per transfer; last flags the final token caused by an input byte.
//   A byte may cause zero, one or two tokens.
//   Throughput: one byte per cycle while the receiver keeps up and the token
//   queue has room; the scanner updates its state once per byte, and the
//   output stage drains one token per cycle from a four-entry token queue.
//   A token is written into the token queue at the edge that accepts the byte
//   closing it and then moves into the output register, from which it is
//   presented; the second token of a byte follows the first through both.
//   When the receiver stalls, the queue fills and in_stall rises once fewer
//   than two entries are free; no token is lost or repeated.
//   The suffix mask register (byte address 0, 64 bits) is written over the
//   APB port while the block is idle, a rule for the user that the block
//   does not enforce. Reset clears the scanner state, the queue and the
//   mask; end of file returns the scanner to its reset state but keeps the mask.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_source_lexer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    character,
	input  wire logic                          src_end,
	// Output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [3:0]                         token_type,
	output logic [15:0]                        line_num,
	output logic [7:0]                         column,
	output logic [8:0]                         length,
	output logic                               last,
	// Configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [asmlex_pkg::CFG_AW-1:0] paddr,
	input  wire logic [63:0]                   pwdata,
	output logic [63:0]                        prdata,
	output logic                               pready
);
	import asmlex_pkg::*;

	logic [63:0] suffix_mask_q;
	logic        in_accept;
	push_t       push;
	token_t      head;
	qstat_t      qstat;
	logic        pop;
	token_t      out_tok;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suffix_mask_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			(paddr[CFG_AW-1] == ADDR_SUFFIX_MASK[CFG_AW-1])) begin
			suffix_mask_q <= pwdata;
		end
	end

	assign prdata = (paddr[CFG_AW-1] == ADDR_SUFFIX_MASK[CFG_AW-1]) ? suffix_mask_q : '0;

	// Accept a byte only when the queue has room for two tokens
	assign in_stall  = qstat.no_room;
	assign in_accept = in_valid && !in_stall;

	asmlex_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.character   (character),
		.src_end     (src_end),
		.suffix_mask (suffix_mask_q),
		.push        (push)
	);

	asmlex_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	asmlex_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (qstat.nonempty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_tok    (out_tok)
	);

	// Drive payload ports
	assign token_type = out_tok.ttype;
	assign line_num   = out_tok.line;
	assign column     = out_tok.col;
	assign length     = out_tok.len;
	assign last       = out_tok.last;

	// Queue never overflows
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.fill <= (QAW+1)'(QDEPTH))
		else $error("token queue overflow");

	// A byte is accepted only with room for two tokens
	a_room_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> (qstat.fill <= (QAW+1)'(QDEPTH - 2)))
		else $error("byte accepted without queue room");

	// End token is always the last of its byte, with zero length and column
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_type == TOK_END)) |-> (last && (length == '0) && (column == '0)))
		else $error("malformed end token");

	// Output holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_tok)))
		else $error("output token changed under stall");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the assembly source lexer.
// Feeds source bytes and end-of-file marks through the valid/stall input
// channel, predicts every token with a behavioral scanner kept in step with
// the accepted transfers, and compares each token leaving the output channel
// field by field. Both channels idle at random; the suffix mask is rewritten
// between sources over the APB port.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import asmlex_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam int SETTLE_CYCLES    = 8;
	localparam int PHASE_BYTES      = 60;

	// Clock, reset and block ports
	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  character   = 8'h00;
	logic        src_end     = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [3:0]  token_type;
	logic [15:0] line_num;
	logic [7:0]  column;
	logic [8:0]  length;
	logic        last;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [63:0] pwdata      = '0;
	logic [63:0] prdata;
	logic        pready;

	// Scanner state mirrored by the token predictor
	logic [63:0] suffix_mask_model = '0;
	mode_t       scan_mode         = MODE_IDLE;
	logic [7:0]  tok_col           = '0;
	logic [8:0]  tok_len           = '0;
	logic        lead_r            = 1'b0;
	logic        second_ok         = 1'b0;
	logic [15:0] line_cnt          = '0;
	logic [8:0]  col_cnt           = '0;
	logic        line_used         = 1'b0;

	token_t expected_tokens[$];
	token_t step_tokens[$];
	token_t want;

	int send_gap_max = 0;
	int stall_max    = 0;
	int stall_cycles;
	int error_count    = 0;
	int tokens_checked = 0;
	int source_bytes   = 0;
	int eof_marks      = 0;
	int masks_written  = 0;

	string word_chars  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._";
	string hex_chars   = "0123456789abcdefABCDEF";
	string digit_chars = "0123456789";
	string symbols     = ":,#()-+";

	assembly_source_lexer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.character(character), .src_end(src_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_type(token_type), .line_num(line_num), .column(column),
		.length(length), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Character classes of the scanner
	function automatic logic digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alpha_byte(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic word_byte(input logic [7:0] c);
		return alpha_byte(c) || digit_byte(c) || c == CH_DOT || c == CH_UNDER;
	endfunction

	function automatic logic hex_byte(input logic [7:0] c);
		return digit_byte(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic space_byte(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Look up the mask bit that governs a register's second byte
	function automatic logic suffix_permitted(input logic [7:0] c);
		int bit_pos;
		if (digit_byte(c)) begin
			bit_pos = c - "0";
		end else if (c >= "A" && c <= "Z") begin
			bit_pos = c - "A" + 10;
		end else if (c >= "a" && c <= "z") begin
			bit_pos = c - "a" + 36;
		end else if (c == CH_DOT) begin
			bit_pos = 62;
		end else if (c == CH_UNDER) begin
			bit_pos = 63;
		end else begin
			return 1'b0;
		end
		return suffix_mask_model[bit_pos];
	endfunction

	function automatic tok_type_t symbol_token(input logic [7:0] c);
		case (c)
			CH_COLON: return TOK_COLON;
			CH_COMMA: return TOK_COMMA;
			CH_HASH:  return TOK_HASH;
			CH_LPAR:  return TOK_LPAREN;
			CH_MINUS: return TOK_MINUS;
			CH_PLUS:  return TOK_PLUS;
			CH_RPAR:  return TOK_RPAREN;
			default:  return TOK_UNKNOWN;
		endcase
	endfunction

	function automatic void add_token(input tok_type_t kind, input logic [8:0] col,
			input logic [8:0] len);
		token_t t;
		t.ttype = kind;
		t.line  = line_cnt;
		t.col   = (col > 9'd255) ? 8'd255 : col[7:0];
		t.len   = len;
		t.last  = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endfunction

	// Close a pending number or word and report it
	function automatic void close_open_token();
		tok_type_t kind;
		if (scan_mode == MODE_IDLE || scan_mode == MODE_COMMENT)
			return;
		if (scan_mode == MODE_DIR)
			kind = TOK_DIRECTIVE;
		else if (scan_mode == MODE_WORD)
			kind = (lead_r && second_ok && tok_len == REG_NAME_LEN) ? TOK_REGISTER : TOK_IDENT;
		else
			kind = TOK_NUMBER;
		add_token(kind, {1'b0, tok_col}, tok_len);
		scan_mode = MODE_IDLE;
	endfunction

	// Advance the predicted scanner by one accepted transfer
	function automatic void lex_step(input logic [7:0] c, input logic eof);
		logic        taken;
		logic [15:0] ln;
		taken = 1'b0;
		if (eof) begin
			ln = line_cnt;
			close_open_token();
			if (line_used && ln != 16'hFFFF)
				ln++;
			line_cnt = ln;
			add_token(TOK_END, '0, '0);
			scan_mode = MODE_IDLE;
			tok_col   = '0;
			tok_len   = '0;
			lead_r    = 1'b0;
			second_ok = 1'b0;
			line_cnt  = '0;
			col_cnt   = '0;
			line_used = 1'b0;
		end else begin
			case (scan_mode)
				MODE_DEC: taken = digit_byte(c);
				MODE_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						scan_mode = MODE_HEX;
						taken = 1'b1;
					end else if (c == CH_LB || c == CH_UB) begin
						scan_mode = MODE_BIN;
						taken = 1'b1;
					end
				end
				MODE_HEX: taken = hex_byte(c);
				MODE_BIN: taken = (c == CH_ZERO || c == CH_ONE);
				MODE_WORD, MODE_DIR: begin
					taken = word_byte(c);
					if (taken && tok_len == 9'd1)
						second_ok = suffix_permitted(c);
				end
				MODE_COMMENT: taken = (c != CH_NL);
				default: taken = 1'b0;
			endcase

			if (taken) begin
				if (scan_mode != MODE_COMMENT && tok_len < 9'd256)
					tok_len++;
			end else begin
				if (scan_mode == MODE_COMMENT)
					scan_mode = MODE_IDLE;
				close_open_token();
				if (c == CH_NL || space_byte(c)) begin
					// separators open nothing
				end else if (c == CH_SEMI) begin
					scan_mode = MODE_COMMENT;
				end else if (word_byte(c)) begin
					if (digit_byte(c))
						scan_mode = (c == CH_ZERO) ? MODE_ZERO : MODE_DEC;
					else
						scan_mode = (c == CH_DOT) ? MODE_DIR : MODE_WORD;
					tok_col   = (col_cnt > 9'd255) ? 8'd255 : col_cnt[7:0];
					tok_len   = 9'd1;
					lead_r    = (c == CH_LR || c == CH_UR);
					second_ok = 1'b0;
				end else begin
					add_token(symbol_token(c), col_cnt, 9'd1);
				end
			end

			// Track line and column position
			if (c == CH_NL) begin
				if (line_cnt != 16'hFFFF)
					line_cnt++;
				col_cnt   = '0;
				line_used = 1'b0;
			end else begin
				if (col_cnt < 9'd256)
					col_cnt++;
				line_used = 1'b1;
			end
		end

		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
		step_tokens.delete();
	endfunction

	// Send one byte or end-of-file mark, then idle for a random gap
	task automatic send_item(input logic [7:0] c, input logic eof);
		int gap;
		@(negedge clk);
		in_valid  <= 1'b1;
		character <= c;
		src_end   <= eof;
		do @(posedge clk); while (in_stall !== 1'b0);
		lex_step(c, eof);
		if (eof)
			eof_marks++;
		else
			source_bytes++;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	// End the source and wait until every token has come out
	task automatic finish_source();
		send_item(8'($urandom_range(0, 255)), 1'b1);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_suffix_mask(input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_SUFFIX_MASK;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		suffix_mask_model = value;
		masks_written++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Hold the output stall for a random number of cycles before each transfer
	initial begin
		forever begin
			stall_cycles = $urandom_range(0, stall_max);
			if (stall_cycles > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (stall_cycles - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Compare each token transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			tokens_checked++;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: type %0d line %0d column %0d length %0d",
					token_type, line_num, column, length);
				error_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (token_type !== want.ttype) begin
					$error("token_type: expected %0d, got %0d", want.ttype, token_type);
					error_count++;
				end
				if (line_num !== want.line) begin
					$error("line_num: expected %0d, got %0d", want.line, line_num);
					error_count++;
				end
				if (column !== want.col) begin
					$error("column: expected %0d, got %0d", want.col, column);
					error_count++;
				end
				if (length !== want.len) begin
					$error("length: expected %0d, got %0d", want.len, length);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					error_count++;
				end
			end
		end
	end

	// End-of-file handling on empty, blank and open sources (reset mask)
	task automatic test_end_of_file();
		send_gap_max = 3;
		stall_max    = 3;
		finish_source();
		send_text("\n");
		finish_source();
		send_text("r1");
		finish_source();
		send_text("ab\n;x");
		finish_source();
	endtask

	// Every token type, every whitespace kind but tab, and the lower-case number prefixes
	task automatic test_directed_tokens();
		write_suffix_mask(64'h2);
		send_gap_max = 0;
		stall_max    = 0;
		send_text("r1:.d #0x1F,0b10(012)+-0x 0b;c\n");
		send_item(CH_VT, 1'b0);
		send_item(CH_FF, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_text("Rx");
		finish_source();
	endtask

	// Register recognition under several suffix masks, extremes included
	task automatic test_suffix_masks();
		logic [63:0] masks[7];
		masks = '{64'h0, '1, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
			64'h2000_0008_0000_0401, 64'h0000_0000_0000_03FF, {$urandom, $urandom}};
		send_gap_max = 19;
		stall_max    = 19;
		foreach (masks[i]) begin
			write_suffix_mask(masks[i]);
			send_text("r_ R. r0 r9 rA rZ ra rz r0a R_\n.r1 r");
			finish_source();
		end
	endtask

	// Column and length counts holding at their limits
	task automatic test_long_lines();
		send_gap_max = 2;
		stall_max    = 2;
		send_text("a");
		repeat (259) send_item(word_chars[$urandom_range(0, 63)], 1'b0);
		send_text(" 77:\n");
		send_text(" ,");
		finish_source();
	endtask

	// One random lexeme, mostly well formed, sometimes noise or end of file
	task automatic send_random_lexeme();
		int kind;
		int idx;
		kind = $urandom_range(0, 99);
		if (kind < 18) begin
			idx = $urandom_range(0, 52);
			send_item((idx == 52) ? CH_UNDER : word_chars[idx], 1'b0);
			repeat ($urandom_range(0, 4)) send_item(word_chars[$urandom_range(0, 63)], 1'b0);
		end else if (kind < 33) begin
			send_item($urandom_range(0, 1) ? CH_LR : CH_UR, 1'b0);
			send_item(word_chars[$urandom_range(0, 63)], 1'b0);
			if ($urandom_range(0, 4) == 0)
				send_item(word_chars[$urandom_range(0, 63)], 1'b0);
		end else if (kind < 40) begin
			send_item(CH_DOT, 1'b0);
			repeat ($urandom_range(0, 4)) send_item(word_chars[$urandom_range(0, 63)], 1'b0);
		end else if (kind < 52) begin
			repeat ($urandom_range(1, 4)) send_item(digit_chars[$urandom_range(0, 9)], 1'b0);
		end else if (kind < 60) begin
			send_item(CH_ZERO, 1'b0);
			case ($urandom_range(0, 3))
				0: send_item(CH_LX, 1'b0);
				1: send_item(CH_UX, 1'b0);
				2: send_item(CH_LB, 1'b0);
				default: send_item(CH_UB, 1'b0);
			endcase
			if (character == CH_LX || character == CH_UX)
				repeat ($urandom_range(0, 4)) send_item(hex_chars[$urandom_range(0, 21)], 1'b0);
			else
				repeat ($urandom_range(0, 4)) send_item($urandom_range(0, 1) ? CH_ONE : CH_ZERO,
					1'b0);
			if ($urandom_range(0, 3) == 0)
				send_item(word_chars[$urandom_range(0, 63)], 1'b0);
		end else if (kind < 72) begin
			send_item(symbols[$urandom_range(0, 6)], 1'b0);
		end else if (kind < 77) begin
			send_item(CH_SEMI, 1'b0);
			repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
			send_item(CH_NL, 1'b0);
		end else if (kind < 95) begin
			case ($urandom_range(0, 9))
				5: send_item(CH_TAB, 1'b0);
				6, 7: send_item(CH_NL, 1'b0);
				8: send_item(CH_CR, 1'b0);
				9: send_item($urandom_range(0, 1) ? CH_VT : CH_FF, 1'b0);
				default: send_item(CH_SPACE, 1'b0);
			endcase
		end else begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end
		if ($urandom_range(0, 59) == 0)
			send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Random sources under varied masks and idling patterns
	task automatic test_random_source();
		logic [63:0] phase_mask[6];
		int gap_max[6];
		int hold_max[6];
		int start;
		phase_mask = '{'1, {$urandom, $urandom}, {$urandom, $urandom}, 64'h0,
			{$urandom, $urandom}, '1};
		gap_max    = '{19, 0, 19, 0, 5, 19};
		hold_max   = '{19, 0, 0, 19, 19, 5};
		foreach (phase_mask[p]) begin
			write_suffix_mask(phase_mask[p]);
			send_gap_max = gap_max[p];
			stall_max    = hold_max[p];
			start = source_bytes + eof_marks;
			while (source_bytes + eof_marks - start < PHASE_BYTES)
				send_random_lexeme();
			finish_source();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_end_of_file();
		test_directed_tokens();
		test_suffix_masks();
		test_long_lines();
		test_random_source();
		$display("Fed %0d source bytes and %0d end-of-file marks under %0d mask settings;",
			source_bytes, eof_marks, masks_written);
		$display("checked %0d tokens including saturated columns and lengths.",
			tokens_checked);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stop a hung run
	initial begin
		#3ms;
		$display("Timeout with %0d tokens still expected", expected_tokens.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/asmlex_pkg.sv
hw/rtl/asmlex_front.sv
hw/rtl/asmlex_queue.sv
hw/rtl/asmlex_back.sv
hw/rtl/assembly_source_lexer_top.sv
sim/testbench.sv
